// ===== sv/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants for the delta list timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int DELTA_W     = 8;
  localparam int ID_W        = 4;
  localparam int OCC_W       = 5;
  localparam int ENTRY_W     = DELTA_W + ID_W;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage

// ===== sv/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/delta_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_core
// Bounded timer queue held as a delta list in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_ready) carry an add (in_func = 0, with
//   in_delay and in_callback_id) or a tick (in_func = 1, with in_elapsed).
//   Every input transaction yields exactly one output transaction
//   (out_valid/out_ready) with fired, fired_id, dropped and occupancy.
//   One item is processed at a time, walking the list through the RAM read
//   port. An add scans to the insert point, shifts the tail up, fixes the
//   successor and writes the new entry; an add that goes to the tail only
//   scans and writes. A tick checks the head and, if it fires, shifts the
//   rest down; a tick that falls short of the head only checks it.
//   A dropped add, an add to an empty queue or a tick on an empty queue is
//   answered from the idle state, its result registered as it is accepted.
//   The result sits in an output register; the next input is taken while it
//   is being read out. While the receiver stalls, a new item is held off.
//   Synchronous reset empties the queue; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module delta_timer_queue_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [dtq_pkg::DELTA_W-1:0] in_delay,
  input  logic [dtq_pkg::ID_W-1:0]    in_callback_id,
  input  logic [dtq_pkg::DELTA_W-1:0] in_elapsed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_fired,
  output logic [dtq_pkg::ID_W-1:0]    out_fired_id,
  output logic                       out_dropped,
  output logic [dtq_pkg::OCC_W-1:0]   out_occupancy
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_SHUP = 7'b0000100,
    ST_FIX  = 7'b0001000,
    ST_INS  = 7'b0010000,
    ST_TCHK = 7'b0100000,
    ST_SHDN = 7'b1000000
  } state_t;

  state_t                          st_r, st_nxt;
  logic [dtq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [dtq_pkg::DELTA_W-1:0]     delay_r, delay_nxt;
  logic [dtq_pkg::ID_W-1:0]        cbid_r, cbid_nxt;
  logic [dtq_pkg::DELTA_W-1:0]     elap_r, elap_nxt;
  logic [dtq_pkg::ADDR_W-1:0]      pos_r, pos_nxt;
  logic [dtq_pkg::DELTA_W-1:0]     dpos_r, dpos_nxt;
  logic [dtq_pkg::ID_W-1:0]        idpos_r, idpos_nxt;
  logic [dtq_pkg::ADDR_W-1:0]      ri_r, ri_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            fired_r, fired_nxt;
  logic [dtq_pkg::ID_W-1:0]        fid_r, fid_nxt;
  logic                            dropped_r, dropped_nxt;
  logic [dtq_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic                            load_out;

  logic                            ram_we, ram_re;
  logic [dtq_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [dtq_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [dtq_pkg::DELTA_W-1:0]     rd_d;
  logic [dtq_pkg::ID_W-1:0]        rd_id;
  logic [dtq_pkg::CNT_W-1:0]       last;
  logic                            ri_last;
  logic [dtq_pkg::DELTA_W-1:0]     sat_d;

  dtq_ram #(
    .WIDTH (dtq_pkg::ENTRY_W),
    .DEPTH (dtq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_d    = ram_rdata[dtq_pkg::ENTRY_W-1:dtq_pkg::ID_W];
  assign rd_id   = ram_rdata[dtq_pkg::ID_W-1:0];
  assign last    = cnt_r - dtq_pkg::CNT_W'(1);
  assign ri_last = (dtq_pkg::CNT_W'(ri_r) == last);
  assign sat_d   = (rd_d > elap_r) ? (rd_d - elap_r) : '0;

  assign in_ready = (st_r == ST_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    delay_nxt     = delay_r;
    cbid_nxt      = cbid_r;
    elap_nxt      = elap_r;
    pos_nxt       = pos_r;
    dpos_nxt      = dpos_r;
    idpos_nxt     = idpos_r;
    ri_nxt        = ri_r;
    out_valid_nxt = out_valid_r;
    fired_nxt     = fired_r;
    fid_nxt       = fid_r;
    dropped_nxt   = dropped_r;
    occ_nxt       = occ_r;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_func == dtq_pkg::FUNC_ADD) begin
            if (cnt_r == dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH)) begin
              load_out    = 1'b1;
              fired_nxt   = 1'b0;
              fid_nxt     = '0;
              dropped_nxt = 1'b1;
              occ_nxt     = dtq_pkg::OCC_W'(cnt_r);
            end else if (cnt_r == '0) begin
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = {in_delay, in_callback_id};
              cnt_nxt     = dtq_pkg::CNT_W'(1);
              load_out    = 1'b1;
              fired_nxt   = 1'b0;
              fid_nxt     = '0;
              dropped_nxt = 1'b0;
              occ_nxt     = dtq_pkg::OCC_W'(1);
            end else begin
              delay_nxt = in_delay;
              cbid_nxt  = in_callback_id;
              ram_re    = 1'b1;
              ram_raddr = '0;
              ri_nxt    = '0;
              st_nxt    = ST_SCAN;
            end
          end else begin
            if (cnt_r == '0) begin
              load_out    = 1'b1;
              fired_nxt   = 1'b0;
              fid_nxt     = '0;
              dropped_nxt = 1'b0;
              occ_nxt     = '0;
            end else begin
              elap_nxt  = in_elapsed;
              ram_re    = 1'b1;
              ram_raddr = '0;
              st_nxt    = ST_TCHK;
            end
          end
        end
      end

      ST_SCAN: begin
        if (delay_r > rd_d) begin
          delay_nxt = delay_r - rd_d;
          if (ri_last) begin
            pos_nxt = ri_r + dtq_pkg::ADDR_W'(1);
            st_nxt  = ST_INS;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ri_r + dtq_pkg::ADDR_W'(1);
            ri_nxt    = ri_r + dtq_pkg::ADDR_W'(1);
          end
        end else begin
          pos_nxt   = ri_r;
          dpos_nxt  = rd_d - delay_r;
          idpos_nxt = rd_id;
          if (ri_last) begin
            st_nxt = ST_FIX;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = dtq_pkg::ADDR_W'(last);
            ri_nxt    = dtq_pkg::ADDR_W'(last);
            st_nxt    = ST_SHUP;
          end
        end
      end

      ST_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = ri_r + dtq_pkg::ADDR_W'(1);
        ram_wdata = ram_rdata;
        if ((ri_r - dtq_pkg::ADDR_W'(1)) != pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = ri_r - dtq_pkg::ADDR_W'(1);
          ri_nxt    = ri_r - dtq_pkg::ADDR_W'(1);
        end else begin
          st_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r + dtq_pkg::ADDR_W'(1);
        ram_wdata = {dpos_r, idpos_r};
        st_nxt    = ST_INS;
      end

      ST_INS: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r;
        ram_wdata   = {delay_r, cbid_r};
        cnt_nxt     = cnt_r + dtq_pkg::CNT_W'(1);
        load_out    = 1'b1;
        fired_nxt   = 1'b0;
        fid_nxt     = '0;
        dropped_nxt = 1'b0;
        occ_nxt     = dtq_pkg::OCC_W'(cnt_r + dtq_pkg::CNT_W'(1));
        st_nxt      = ST_IDLE;
      end

      ST_TCHK: begin
        if (elap_r < rd_d) begin
          load_out    = 1'b1;
          fired_nxt   = 1'b0;
          fid_nxt     = '0;
          dropped_nxt = 1'b0;
          occ_nxt     = dtq_pkg::OCC_W'(cnt_r);
          st_nxt      = ST_IDLE;
        end else begin
          idpos_nxt = rd_id;
          elap_nxt  = elap_r - rd_d;
          if (cnt_r == dtq_pkg::CNT_W'(1)) begin
            cnt_nxt     = '0;
            load_out    = 1'b1;
            fired_nxt   = 1'b1;
            fid_nxt     = rd_id;
            dropped_nxt = 1'b0;
            occ_nxt     = '0;
            st_nxt      = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = dtq_pkg::ADDR_W'(1);
            ri_nxt    = dtq_pkg::ADDR_W'(1);
            st_nxt    = ST_SHDN;
          end
        end
      end

      ST_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = ri_r - dtq_pkg::ADDR_W'(1);
        ram_wdata = (ri_r == dtq_pkg::ADDR_W'(1)) ? {sat_d, rd_id} : ram_rdata;
        if (!ri_last) begin
          ram_re    = 1'b1;
          ram_raddr = ri_r + dtq_pkg::ADDR_W'(1);
          ri_nxt    = ri_r + dtq_pkg::ADDR_W'(1);
        end else begin
          cnt_nxt     = last;
          load_out    = 1'b1;
          fired_nxt   = 1'b1;
          fid_nxt     = idpos_r;
          dropped_nxt = 1'b0;
          occ_nxt     = dtq_pkg::OCC_W'(last);
          st_nxt      = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delay_r   <= delay_nxt;
    cbid_r    <= cbid_nxt;
    elap_r    <= elap_nxt;
    pos_r     <= pos_nxt;
    dpos_r    <= dpos_nxt;
    idpos_r   <= idpos_nxt;
    ri_r      <= ri_nxt;
    fired_r   <= fired_nxt;
    fid_r     <= fid_nxt;
    dropped_r <= dropped_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_fired     = fired_r;
  assign out_fired_id  = fid_r;
  assign out_dropped   = dropped_r;
  assign out_occupancy = occ_r;

endmodule

// ===== sv/dtq_chk.sv =====
// ----------------------------------------------------------------------------
// dtq_chk
// Port level checks for the delta list timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_fired,
  input logic [dtq_pkg::ID_W-1:0]    out_fired_id,
  input logic                        out_dropped,
  input logic [dtq_pkg::OCC_W-1:0]   out_occupancy
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired) &&
    $stable(out_fired_id) && $stable(out_dropped) && $stable(out_occupancy))
    else $error("output transaction changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fired && out_dropped))
    else $error("fired and dropped both set");

  a_fid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_id == '0)
    else $error("fired_id nonzero without fire");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |->
    out_occupancy == dtq_pkg::OCC_W'(dtq_pkg::QUEUE_DEPTH))
    else $error("drop reported on a queue that is not full");

  // a new transaction only while the result slot is free or draining
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input accepted while result stalled");

endmodule

bind delta_timer_queue_core dtq_chk u_dtq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fired     (out_fired),
  .out_fired_id  (out_fired_id),
  .out_dropped   (out_dropped),
  .out_occupancy (out_occupancy)
);
